// File: rtl/core/tcw_pkg.sv
// shared types, constants and helpers for the text console writer
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int IDX_W      = $clog2(CELLS);
   localparam int COORD_W    = 16;
   localparam int RECIP_SH   = 20;
   localparam int PROD_W     = COORD_W + RECIP_SH;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int CELL_W     = 16;
   localparam int CURSOR_W   = 11;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RECIP_SH-1:0] COL_RECIP = RECIP_SH'((2 ** RECIP_SH) / COLUMNS);
   localparam logic [RECIP_SH-1:0] ROW_RECIP = RECIP_SH'((2 ** RECIP_SH) / ROWS);

   localparam logic [CHAR_W-1:0]  NEWLINE    = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE      = 8'd32;
   localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;
   localparam logic [CELL_W-1:0]  CELL_RESET = 16'h0720;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_SET   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG    = 2'd0,
      CSR_BG    = 2'd1,
      CSR_BLINK = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_QUOT,
      F_REM,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_CLEAR,
      B_SCROLL_RD,
      B_SCROLL_WR,
      B_BLANK,
      B_FINISH
   } back_state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [CHAR_W-1:0]  char_code;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
   } cmd_entry_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0]  ch,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg,
                                                   input logic               blink);
      make_cell = {bg[COLOR_W-1] | blink, bg[COLOR_W-2:0], fg, ch};
   endfunction

endpackage

// File: rtl/core/tcw_front.sv
// front end: takes command beats and reduces coordinates by reciprocal multiplication
module tcw_front import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [COORD_W-1:0]  req_col,
   input  logic [COORD_W-1:0]  req_row,
   input  logic                init_busy,
   output logic                q_push,
   input  logic                q_full,
   output cmd_entry_type       q_entry
);

   front_state_type       state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [COORD_W-1:0]    col_raw_ff, col_raw_in;
   logic [COORD_W-1:0]    row_raw_ff, row_raw_in;
   logic [COORD_W-1:0]    col_quot_ff, col_quot_in;
   logic [COORD_W-1:0]    row_quot_ff, row_quot_in;
   logic [COL_W:0]        col_rem_ff, col_rem_in;
   logic [ROW_W:0]        row_rem_ff, row_rem_in;
   logic [PROD_W-1:0]     col_prod, row_prod;
   logic [COORD_W-1:0]    col_diff, row_diff;
   logic [COL_W-1:0]      col_mod;
   logic [ROW_W-1:0]      row_mod;
   cmd_type               req_cmd_e;

   assign req_cmd_e = cmd_type'(req_cmd);
   // quotient estimate is low by at most one
   assign col_prod  = PROD_W'(col_raw_ff) * PROD_W'(COL_RECIP);
   assign row_prod  = PROD_W'(row_raw_ff) * PROD_W'(ROW_RECIP);
   assign col_diff  = col_raw_ff - col_quot_ff * COORD_W'(COLUMNS);
   assign row_diff  = row_raw_ff - row_quot_ff * COORD_W'(ROWS);
   assign col_mod   = (col_rem_ff >= (COL_W+1)'(COLUMNS)) ?
                      COL_W'(col_rem_ff - (COL_W+1)'(COLUMNS)) : COL_W'(col_rem_ff);
   assign row_mod   = (row_rem_ff >= (ROW_W+1)'(ROWS)) ?
                      ROW_W'(row_rem_ff - (ROW_W+1)'(ROWS)) : ROW_W'(row_rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff      <= cmd_in;
      col_raw_ff  <= col_raw_in;
      row_raw_ff  <= row_raw_in;
      col_quot_ff <= col_quot_in;
      row_quot_ff <= row_quot_in;
      col_rem_ff  <= col_rem_in;
      row_rem_ff  <= row_rem_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      col_raw_in  = col_raw_ff;
      row_raw_in  = row_raw_ff;
      col_quot_in = col_quot_ff;
      row_quot_in = row_quot_ff;
      col_rem_in  = col_rem_ff;
      row_rem_in  = row_rem_ff;
      req_full    = (state_ff != F_IDLE) || q_full || init_busy;
      q_push      = 1'b0;
      q_entry     = '{cmd: req_cmd_e, char_code: req_char_code, col: '0, row: '0};
      case (state_ff)
         F_IDLE: begin
            if (req_push && !req_full) begin
               if (req_cmd_e inside {CMD_WRITE, CMD_CLEAR}) begin
                  q_push = 1'b1;
               end else begin
                  cmd_in     = req_cmd_e;
                  col_raw_in = req_col;
                  row_raw_in = req_row;
                  state_in   = F_QUOT;
               end
            end
         end
         F_QUOT: begin
            col_quot_in = COORD_W'(col_prod >> RECIP_SH);
            row_quot_in = COORD_W'(row_prod >> RECIP_SH);
            state_in    = F_REM;
         end
         F_REM: begin
            col_rem_in = (COL_W+1)'(col_diff);
            row_rem_in = (ROW_W+1)'(row_diff);
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            q_entry = '{cmd: cmd_ff, char_code: '0, col: col_mod, row: row_mod};
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/tcw_queue.sv
// short command queue between front and back ends
module tcw_queue import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  cmd_entry_type  push_entry,
   input  logic           pop,
   output logic           empty,
   output cmd_entry_type  pop_entry
);

   cmd_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/tcw_back.sv
// back end: screen memory, cursor, scroll and clear sweeps, result register
module tcw_back import tcw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   q_empty,
   input  cmd_entry_type          q_entry,
   output logic                   q_pop,
   output logic                   init_busy,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CURSOR_W-1:0]    rsp_cursor_index,
   output logic [CHAR_W-1:0]      rsp_read_char
);

   logic [CELL_W-1:0]     cells_mem [CELLS];
   logic [CELL_W-1:0]     rdata_ff;

   back_state_type        state_ff, state_in;
   cmd_type               op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [COL_W-1:0]      cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]      cursor_row_ff, cursor_row_in;
   logic [CURSOR_W-1:0]   shown_ff, shown_in;
   logic [COLOR_W-1:0]    fg_ff, bg_ff;
   logic                  blink_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0]   rsp_cursor_ff, rsp_cursor_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa, mem_ra;
   logic [CELL_W-1:0]     mem_wd;
   logic [IDX_W-1:0]      cursor_lin, entry_lin;
   logic                  slot_free;
   logic [CELL_W-1:0]     space_cell;

   assign cursor_lin = IDX_W'(cursor_col_ff) + IDX_W'(cursor_row_ff) * IDX_W'(COLUMNS);
   assign entry_lin  = IDX_W'(q_entry.col) + IDX_W'(q_entry.row) * IDX_W'(COLUMNS);
   assign slot_free  = !rsp_valid_ff || rsp_pop;
   assign space_cell = make_cell(SPACE, fg_ff, bg_ff, blink_ff);
   assign init_busy  = (state_ff == B_INIT);

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_cursor_index = rsp_cursor_ff;
   assign rsp_read_char    = rsp_char_ff;

   // attribute registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff    <= FG_RESET;
         bg_ff    <= BG_RESET;
         blink_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FG:    fg_ff    <= csr_data;
            CSR_BG:    bg_ff    <= csr_data;
            CSR_BLINK: blink_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // screen memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= cells_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_INIT;
         idx_ff        <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         shown_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         shown_ff      <= shown_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      shown_in      = shown_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = space_cell;
      mem_ra        = idx_ff;
      q_pop         = 1'b0;
      case (state_ff)
         B_INIT: begin
            mem_we = 1'b1;
            mem_wd = CELL_RESET;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(CELLS - 1)) begin
               idx_in   = '0;
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop    = 1'b1;
               op_in    = q_entry.cmd;
               state_in = B_FINISH;
               case (q_entry.cmd)
                  CMD_WRITE: begin
                     if (q_entry.char_code != NEWLINE) begin
                        mem_we = 1'b1;
                        mem_wa = cursor_lin;
                        mem_wd = make_cell(q_entry.char_code, fg_ff, bg_ff, blink_ff);
                        cursor_col_in = cursor_col_ff + 1'b1;
                     end
                     if (q_entry.char_code == NEWLINE ||
                         cursor_col_ff == COL_W'(COLUMNS - 1)) begin
                        cursor_col_in = '0;
                        if (cursor_row_ff == ROW_W'(ROWS - 1)) begin
                           idx_in   = '0;
                           state_in = B_SCROLL_RD;
                        end else begin
                           cursor_row_in = cursor_row_ff + 1'b1;
                        end
                     end
                  end
                  CMD_SET: begin
                     cursor_col_in = q_entry.col;
                     cursor_row_in = q_entry.row;
                  end
                  CMD_READ: begin
                     mem_ra = entry_lin;
                  end
                  CMD_CLEAR: begin
                     cursor_col_in = '0;
                     cursor_row_in = '0;
                     idx_in        = '0;
                     state_in      = B_CLEAR;
                  end
                  default: begin
                     state_in = B_FINISH;
                  end
               endcase
            end
         end
         B_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(CELLS - 1)) begin
               state_in = B_FINISH;
            end
         end
         B_SCROLL_RD: begin
            mem_ra   = idx_ff + IDX_W'(COLUMNS);
            state_in = B_SCROLL_WR;
         end
         B_SCROLL_WR: begin
            mem_we   = 1'b1;
            mem_wd   = make_cell(rdata_ff[CHAR_W-1:0], fg_ff, bg_ff, blink_ff);
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == IDX_W'(CELLS - COLUMNS - 1)) ? B_BLANK : B_SCROLL_RD;
         end
         B_BLANK: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(CELLS - 1)) begin
               state_in = B_FINISH;
            end
         end
         B_FINISH: begin
            if (op_ff inside {CMD_WRITE, CMD_CLEAR}) begin
               shown_in      = CURSOR_W'(cursor_lin);
               rsp_cursor_in = CURSOR_W'(cursor_lin);
            end else begin
               rsp_cursor_in = shown_ff;
            end
            rsp_valid_in  = 1'b1;
            rsp_char_in   = (op_ff == CMD_READ) ? rdata_ff[CHAR_W-1:0] : '0;
            state_in      = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_col_ff} < (COL_W+1)'(COLUMNS))
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_row_ff} < (ROW_W+1)'(ROWS))
      else $error("cursor row out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == B_FINISH)
      else $error("result loaded outside finish");

   a_scroll_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_SCROLL_WR |-> $past(state_ff) == B_SCROLL_RD)
      else $error("scroll write without preceding read");

endmodule

// File: rtl/core/text_console_writer_top.sv
// top level of the text console writer
// Text console on an 80 x 25 screen. After reset the block initializes all 2000
// cells of the screen memory (one cell per cycle) and holds req_full high;
// csr writes are taken at any time. Every command enters a small command queue;
// set cursor and read first pass through the front end, which reduces col
// and row by a reciprocal multiplication and a compare and subtract. The back
// end handles a write, set or read in B_IDLE and B_FINISH; a clear walks all
// 2000 cells and a scroll, caused by leaving the last row, copies 1920 cells
// (a read, then a write, for each) and then blanks 80 cells. A result that is
// not popped holds the back end. One result beat is produced per command.
module text_console_writer_top import tcw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic [COORD_W-1:0]     req_col,
   input  logic [COORD_W-1:0]     req_row,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CURSOR_W-1:0]    rsp_cursor_index,
   output logic [CHAR_W-1:0]      rsp_read_char,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic           q_push, q_full, q_pop, q_empty, init_busy;
   cmd_entry_type  q_push_entry, q_pop_entry;

   assign csr_ready = 1'b1;

   tcw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .init_busy     (init_busy),
      .q_push        (q_push),
      .q_full        (q_full),
      .q_entry       (q_push_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .full       (q_full),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_pop_entry)
   );

   tcw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_empty          (q_empty),
      .q_entry          (q_pop_entry),
      .q_pop            (q_pop),
      .init_busy        (init_busy),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cursor_index (rsp_cursor_index),
      .rsp_read_char    (rsp_read_char)
   );

endmodule

// File: tb/sv/text_console_writer_checker.sv
// checker for the text console writer: predicts every result beat and compares it
module text_console_writer_checker import tcw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [CURSOR_W-1:0]   rsp_cursor_index,
   input  logic [CHAR_W-1:0]     rsp_read_char,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_index;
      logic [CHAR_W-1:0]   read_char;
   } console_reply_type;

   logic [CELL_W-1:0]  screen [CELLS];
   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;
   logic               blink_on;
   logic [COL_W-1:0]   cur_col;
   logic [ROW_W-1:0]   cur_row;
   logic [CURSOR_W-1:0] shown_cursor;
   console_reply_type  replies_due[$];
   int                 errors = 0;

   function automatic logic [CELL_W-1:0] encode_cell(input logic [CHAR_W-1:0] ch);
      logic [CELL_W-1:0] cell_word;
      cell_word = {bg_color, fg_color, ch};
      cell_word[CELL_W-1] = cell_word[CELL_W-1] | blink_on;
      return cell_word;
   endfunction

   function automatic void fill_blank();
      for (int i = 0; i < CELLS; i++) screen[i] = encode_cell(SPACE);
   endfunction

   function automatic void latch_cursor();
      int linear;
      linear = int'(cur_col) + int'(cur_row) * COLUMNS;
      shown_cursor = linear[CURSOR_W-1:0];
   endfunction

   function automatic void scroll_up();
      for (int i = 0; i < CELLS - COLUMNS; i++)
         screen[i] = encode_cell(screen[i + COLUMNS][CHAR_W-1:0]);
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = encode_cell(SPACE);
   endfunction

   function automatic void line_feed();
      cur_col = '0;
      if (int'(cur_row) + 1 >= ROWS) begin
         cur_row = ROW_W'(ROWS - 1);
         scroll_up();
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   function automatic void type_character(input logic [CHAR_W-1:0] ch);
      if (ch == NEWLINE) begin
         line_feed();
      end else begin
         screen[int'(cur_col) + int'(cur_row) * COLUMNS] = encode_cell(ch);
         cur_col = cur_col + 1'b1;
         if (int'(cur_col) >= COLUMNS) line_feed();
      end
      latch_cursor();
   endfunction

   function automatic void apply_console_command(input cmd_type cmd,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [COORD_W-1:0] col_in,
                                                 input logic [COORD_W-1:0] row_in);
      console_reply_type reply;
      int c;
      int r;
      c = int'(col_in) % COLUMNS;
      r = int'(row_in) % ROWS;
      reply.read_char = '0;
      case (cmd)
         CMD_WRITE: type_character(ch);
         CMD_SET: begin
            cur_col = c[COL_W-1:0];
            cur_row = r[ROW_W-1:0];
         end
         CMD_READ: reply.read_char = screen[c + r * COLUMNS][CHAR_W-1:0];
         CMD_CLEAR: begin
            fill_blank();
            cur_col = '0;
            cur_row = '0;
            latch_cursor();
         end
         default: ;
      endcase
      reply.cursor_index = shown_cursor;
      replies_due.push_back(reply);
   endfunction

   function automatic void check_reply();
      console_reply_type due;
      if (replies_due.size() == 0) begin
         $display("%t unexpected result beat: expected none, actual cursor %0d char %0d",
                  $time, rsp_cursor_index, rsp_read_char);
         errors++;
      end else begin
         due = replies_due.pop_front();
         if (due.cursor_index !== rsp_cursor_index) begin
            $display("%t cursor_index mismatch: expected %0d actual %0d",
                     $time, due.cursor_index, rsp_cursor_index);
            errors++;
         end
         if (due.read_char !== rsp_read_char) begin
            $display("%t read_char mismatch: expected %0d actual %0d",
                     $time, due.read_char, rsp_read_char);
            errors++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = CELL_RESET;
         fg_color = FG_RESET;
         bg_color = BG_RESET;
         blink_on = 1'b0;
         cur_col = '0;
         cur_row = '0;
         shown_cursor = '0;
         replies_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_reply();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FG:    fg_color = csr_data[COLOR_W-1:0];
               CSR_BG:    bg_color = csr_data[COLOR_W-1:0];
               CSR_BLINK: blink_on = csr_data[0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            apply_console_command(cmd_type'(req_cmd), req_char_code, req_col, req_row);
      end
      fail_count <= errors;
      pending_results <= replies_due.size();
   end

endmodule

// File: tb/sv/tb.sv
// testbench top for the text console writer: stimulus, result sink and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int PERIOD          = 10;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 313;
   localparam int BACKEND_SETTLE  = 4000;
   localparam int HOLD_AFTER      = 400;
   localparam int LONG_HOLD       = 600;
   localparam int CYCLE_LIMIT     = 4_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [CMD_W-1:0]      req_cmd = CMD_WRITE;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [COORD_W-1:0]    req_col = '0;
   logic [COORD_W-1:0]    req_row = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [CURSOR_W-1:0]   rsp_cursor_index;
   logic [CHAR_W-1:0]     rsp_read_char;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FG;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    pending_results;

   always #(PERIOD / 2) clock = ~clock;

   text_console_writer_top DUT (.*);

   text_console_writer_checker checker_i (.*);

   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [COORD_W-1:0] any_coord();
      return COORD_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [COORD_W-1:0] random_coord(input int span);
      if ($urandom_range(0, 1)) return any_coord();
      return COORD_W'($urandom_range(0, span - 1));
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      if ($urandom_range(0, 9) == 0) return NEWLINE;
      return any_char();
   endfunction

   task automatic offer_command(input cmd_type cmd, input logic [CHAR_W-1:0] ch,
                                input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row);
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_char_code <= ch;
      req_col <= col;
      req_row <= row;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_settings(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                 input logic blink);
      logic [CSR_DATA_W-1:0] blink_data;
      blink_data = CSR_DATA_W'($urandom_range(0, 15));
      blink_data[0] = blink;
      csr_beat(CSR_FG, fg);
      csr_beat(CSR_BG, bg);
      csr_beat(CSR_BLINK, blink_data);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      offer_command(CMD_READ, any_char(), '0, '0);
      offer_command(CMD_WRITE, 8'h41, any_coord(), any_coord());
      offer_command(CMD_WRITE, 8'h00, any_coord(), any_coord());
      offer_command(CMD_WRITE, 8'hFF, any_coord(), any_coord());
      offer_command(CMD_WRITE, NEWLINE, any_coord(), any_coord());
      offer_command(CMD_READ, any_char(), '0, '0);
      offer_command(CMD_READ, any_char(), 16'd2, '0);
      offer_command(CMD_READ, any_char(), 16'hFFFF, 16'hFFFF);
      offer_command(CMD_SET, any_char(), 16'hFFFF, 16'hFFFF);
      offer_command(CMD_WRITE, 8'h7E, any_coord(), any_coord());
      offer_command(CMD_SET, any_char(), COORD_W'(COLUMNS), COORD_W'(ROWS));
      offer_command(CMD_READ, any_char(), '0, '0);
      offer_command(CMD_SET, any_char(), COORD_W'(COLUMNS - 2), 16'd3);
      repeat (3) offer_command(CMD_WRITE, any_char(), any_coord(), any_coord());
      // last cell: wrap off the bottom row, then newline on the bottom row
      offer_command(CMD_SET, any_char(), COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1));
      offer_command(CMD_WRITE, 8'h5A, any_coord(), any_coord());
      offer_command(CMD_READ, any_char(), COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 2));
      offer_command(CMD_WRITE, NEWLINE, any_coord(), any_coord());
      offer_command(CMD_READ, any_char(), COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 3));
      offer_command(CMD_CLEAR, any_char(), any_coord(), any_coord());
      offer_command(CMD_READ, any_char(), COORD_W'(COLUMNS - 1), COORD_W'(ROWS - 1));
      offer_command(CMD_WRITE, NEWLINE, any_coord(), any_coord());
   endtask

   task automatic run_random(input int count);
      int sent;
      int burst;
      int kind;
      int pick;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         kind = $urandom_range(0, 9);
         for (int n = 0; n < burst && sent < count; n++) begin
            if (kind == 0) begin
               // park near the end of the bottom row and type past it
               if (n == 0)
                  offer_command(CMD_SET, any_char(),
                                COORD_W'(COLUMNS - 1 - $urandom_range(0, 7)
                                         + COLUMNS * $urandom_range(0, 800)),
                                COORD_W'(ROWS - 1 + ROWS * $urandom_range(0, 2600)));
               else if (n < burst - 2)
                  offer_command(CMD_WRITE, random_char(), any_coord(), any_coord());
               else
                  offer_command(CMD_READ, any_char(), random_coord(COLUMNS),
                                random_coord(ROWS));
            end else if (kind == 1) begin
               offer_command(CMD_READ, any_char(), random_coord(COLUMNS), random_coord(ROWS));
            end else begin
               pick = $urandom_range(0, 199);
               if (pick < 110)
                  offer_command(CMD_WRITE, random_char(), any_coord(), any_coord());
               else if (pick < 140)
                  offer_command(CMD_SET, any_char(), random_coord(COLUMNS),
                                random_coord(ROWS));
               else if (pick < 197)
                  offer_command(CMD_READ, any_char(), random_coord(COLUMNS),
                                random_coord(ROWS));
               else
                  offer_command(CMD_CLEAR, any_char(), any_coord(), any_coord());
            end
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin : result_sink
      int cycle;
      int taken;
      int hold;
      bit held;
      cycle = 0;
      taken = 0;
      hold = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold != 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            case ((cycle / 97) % 4)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= ($urandom_range(0, 1) == 1);
               2: rsp_pop <= (cycle % 5 == 0);
               default: rsp_pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
         cycle++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%t timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_beat(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 15)));
      write_settings(FG_RESET, BG_RESET, 1'b0);
      run_directed();
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         repeat (BACKEND_SETTLE) @(posedge clock);
         case (phase)
            0: write_settings(4'hF, 4'hF, 1'b1);
            1: write_settings(4'h0, 4'h0, 1'b0);
            2: write_settings(4'hF, 4'h0, 1'b1);
            3: write_settings(4'h0, 4'hF, 1'b0);
            default: write_settings(COLOR_W'($urandom_range(0, 15)),
                                    COLOR_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1)));
         endcase
         run_random(ITEMS_PER_PHASE);
      end
      drain_results();
      repeat (BACKEND_SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer_top.sv
tb/sv/text_console_writer_checker.sv
tb/sv/tb.sv
